// ----- src/ecmb_pkg.sv -----
package ecmb_pkg;

	// Default RAM depth and the reset address of the command/status port
	localparam int unsigned MEMORY_DEPTH = 256;
	localparam logic [15:0] COMMAND_PORT_RESET = 16'h0066;
	// Data port sits this far below the command port
	localparam logic [15:0] DATA_PORT_OFFSET = 16'd4;

	// Host command codes
	localparam logic [7:0] CMD_READ_MEM = 8'h80;
	localparam logic [7:0] CMD_WRITE_MEM = 8'h81;

	// Status byte bit positions
	localparam int unsigned STATUS_OBF_BIT = 0;
	localparam int unsigned STATUS_IBF_BIT = 1;

	// Decode of the word at the input, datapath to controller
	typedef struct packed {
		logic hit_cmd;
		logic hit_data;
		logic is_write;
		logic cmd_read;
		logic cmd_write;
	} ecmb_status_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic take;       // capture the result of the accepted word
		logic off_latch;  // latch the RAM offset
		logic rd_start;   // start a RAM read at the offset
		logic mem_wr;     // store the byte at the latched offset
		logic obf_load;   // load the output buffer from the RAM read
		logic obf_clear;  // data port read empties the output buffer
	} ecmb_cmd_t;

endpackage

// ----- src/ecmb_ctrl.sv -----
module ecmb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  ecmb_pkg::ecmb_status_t status,
	output ecmb_pkg::ecmb_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_LOAD
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RD_OFFSET,
		PH_WR_OFFSET,
		PH_WR_VALUE
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic   out_valid_q;
	logic   accept;
	logic   data_wr;

	// Input taken while idle and the result slot is free or draining
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign data_wr   = accept && status.hit_data && status.is_write;

	// Command decode
	always_comb begin
		cmd.take      = accept;
		cmd.off_latch = data_wr && (phase_q == PH_RD_OFFSET || phase_q == PH_WR_OFFSET);
		cmd.rd_start  = data_wr && (phase_q == PH_RD_OFFSET);
		cmd.mem_wr    = data_wr && (phase_q == PH_WR_VALUE);
		cmd.obf_load  = (state_q == ST_LOAD);
		cmd.obf_clear = accept && status.hit_data && !status.is_write;
	end

	// Sequencer, protocol phase and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd.rd_start) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (accept && status.hit_cmd && status.is_write) begin
				if (status.cmd_read) begin
					phase_q <= PH_RD_OFFSET;
				end else if (status.cmd_write) begin
					phase_q <= PH_WR_OFFSET;
				end else begin
					phase_q <= PH_IDLE;
				end
			end else if (data_wr) begin
				case (phase_q)
					PH_RD_OFFSET: phase_q <= PH_IDLE;
					PH_WR_OFFSET: phase_q <= PH_WR_VALUE;
					PH_WR_VALUE:  phase_q <= PH_IDLE;
					default:      phase_q <= PH_IDLE;
				endcase
			end
		end
	end

endmodule

// ----- src/ecmb_dp.sv -----
module ecmb_dp #(
	parameter int unsigned MemDepth = ecmb_pkg::MEMORY_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	input  logic                   func,
	input  logic [15:0]            io_address,
	input  logic [7:0]             write_data,
	input  ecmb_pkg::ecmb_cmd_t    cmd,
	output ecmb_pkg::ecmb_status_t status,
	output logic [7:0]             read_data,
	output logic                   claimed
);

	localparam int unsigned AddrW = $clog2(MemDepth);

	logic [15:0]      command_port_q;
	logic [15:0]      data_port;
	logic [7:0]       latched_offset_q;
	logic [7:0]       output_byte_q;
	logic             output_full_q;
	logic [7:0]       mem [MemDepth];
	logic [MemDepth-1:0] valid_q;
	logic [7:0]       ram_q;
	logic             rd_ok_q;
	logic             rd_in_range;
	logic             wr_in_range;
	logic [7:0]       result;

	// Port decode
	assign data_port = command_port_q - ecmb_pkg::DATA_PORT_OFFSET;

	always_comb begin
		status.hit_cmd   = (io_address == command_port_q);
		status.hit_data  = !status.hit_cmd && (io_address == data_port);
		status.is_write  = func;
		status.cmd_read  = (write_data == ecmb_pkg::CMD_READ_MEM);
		status.cmd_write = (write_data == ecmb_pkg::CMD_WRITE_MEM);
	end

	assign rd_in_range = ({1'b0, write_data} < 9'(MemDepth));
	assign wr_in_range = ({1'b0, latched_offset_q} < 9'(MemDepth));

	// Result byte: status for command reads, buffer for data reads
	always_comb begin
		result = 8'h00;
		if (status.hit_cmd && !func) begin
			result[ecmb_pkg::STATUS_OBF_BIT] = output_full_q;
			result[ecmb_pkg::STATUS_IBF_BIT] = 1'b0;
		end else if (status.hit_data && !func) begin
			result = output_byte_q;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_port_q <= ecmb_pkg::COMMAND_PORT_RESET;
		end else if (cfg_we) begin
			command_port_q <= cfg_wdata;
		end
	end

	// Protocol registers and output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_offset_q <= 8'h00;
			output_byte_q    <= 8'h00;
			output_full_q    <= 1'b0;
			rd_ok_q          <= 1'b0;
		end else begin
			if (cmd.off_latch) begin
				latched_offset_q <= write_data;
			end
			if (cmd.rd_start) begin
				rd_ok_q <= rd_in_range && valid_q[write_data[AddrW-1:0]];
			end
			if (cmd.obf_load) begin
				output_byte_q <= rd_ok_q ? ram_q : 8'h00;
				output_full_q <= 1'b1;
			end else if (cmd.obf_clear) begin
				output_full_q <= 1'b0;
			end
		end
	end

	// Per-entry written marks; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.mem_wr && wr_in_range) begin
			valid_q[latched_offset_q[AddrW-1:0]] <= 1'b1;
		end
	end

	// Byte RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_in_range) begin
			mem[latched_offset_q[AddrW-1:0]] <= write_data;
		end
		if (cmd.rd_start) begin
			ram_q <= mem[write_data[AddrW-1:0]];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			read_data <= result;
			claimed   <= status.hit_cmd || status.hit_data;
		end
	end

endmodule

// ----- src/ec_host_mailbox_ram.sv -----
// Host I/O port pair of an embedded controller with a byte RAM mailbox.
// Latency: the result word is registered and offered in the cycle after the access is accepted.
// Throughput: one access per cycle while the result slot is free or draining;
// a read-offset data write stalls the next word during the registered RAM fetch.
// Reset (arst_n, asynchronous): protocol idle, buffer empty, command port 0x66;
// RAM reads as zero at once through per-entry written marks, no clearing pass.
module ec_host_mailbox_ram #(
	parameter int unsigned MemDepth = ecmb_pkg::MEMORY_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,       // command_port
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // io_address[15:0], write_data[23:16]
	input  logic        s_axis_tuser,    // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,    // read_data[7:0]
	output logic        m_axis_tuser     // claimed
);

	ecmb_pkg::ecmb_status_t status;
	ecmb_pkg::ecmb_cmd_t    cmd;

	ecmb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	ecmb_dp #(
		.MemDepth (MemDepth)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.func       (s_axis_tuser),
		.io_address (s_axis_tdata[15:0]),
		.write_data (s_axis_tdata[23:16]),
		.cmd        (cmd),
		.status     (status),
		.read_data  (m_axis_tdata),
		.claimed    (m_axis_tuser)
	);

	// RAM fetch cycle blocks the next word
	a_fetch_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_start |=> !s_axis_tready)
		else $error("word accepted during RAM fetch");

	// Unclaimed access never returns data
	a_unclaimed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'h00))
		else $error("unclaimed access returned data");

	// Status read shows only the output buffer flag
	a_status_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && status.hit_cmd && !s_axis_tuser)
		|=> (m_axis_tdata[7:1] == 7'h00))
		else $error("status byte has stray bits");

endmodule

// ----- tb/ec_host_mailbox_ram_tb.sv -----
`timescale 1ns / 1ps

module ec_host_mailbox_ram_tb;

	// One host I/O access and the word the block returns for it
	typedef struct packed {
		logic        is_wr;
		logic [15:0] addr;
		logic [7:0]  byte_in;
	} host_access_t;

	typedef struct packed {
		logic [7:0] rd_byte;
		logic       claimed;
	} host_reply_t;

	// Directed row: access, and a typed-in reply where it is obvious
	typedef struct packed {
		host_access_t acc;
		logic         exact;
		host_reply_t  reply;
	} dir_row_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RD_OFF,
		PH_WR_OFF,
		PH_WR_VAL
	} host_phase_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [15:0] CMD_PORT0 = ecmb_pkg::COMMAND_PORT_RESET;
	localparam logic [15:0] DATA_PORT0 =
		ecmb_pkg::COMMAND_PORT_RESET - ecmb_pkg::DATA_PORT_OFFSET;
	localparam logic [7:0] OBF_SET = 8'(1 << ecmb_pkg::STATUS_OBF_BIT);
	localparam logic [7:0] CMD_UNKNOWN = 8'h55;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;    // io_address[15:0], write_data[23:16]
	logic        s_axis_tuser;    // func
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;    // read_data[7:0]
	logic        m_axis_tuser;    // claimed

	// Travels beside the input word: typed-in reply for directed rows
	logic        row_exact;
	host_reply_t row_reply;

	// Mirror of the mailbox state
	logic [7:0]  ec_ram [ecmb_pkg::MEMORY_DEPTH];
	host_phase_t ec_phase;
	logic [7:0]  ec_offset;
	logic [7:0]  ec_obuf;
	logic        ec_obf;
	logic [15:0] ec_cmd_port;

	host_reply_t  reply_q [$];
	host_reply_t  want_reply;
	host_reply_t  next_reply;
	host_access_t seen_acc;
	int           errors;
	int           sent_count;
	int           send_idle_pct;
	int           recv_stall_pct;
	bit           pressure_on;
	int           stall_cycles;

	dir_row_t dir_tab [27] = '{
		// after reset: status empty, data buffer zero
		'{'{1'b0, CMD_PORT0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b0, DATA_PORT0, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
		// unclaimed addresses, extremes and near misses
		'{'{1'b0, 16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
		'{'{1'b1, 16'hFFFF, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
		'{'{1'b0, 16'h0067, 8'h00}, 1'b1, '{8'h00, 1'b0}},
		'{'{1'b1, 16'h0063, ecmb_pkg::CMD_WRITE_MEM}, 1'b1, '{8'h00, 1'b0}},
		// stray data write in idle
		'{'{1'b1, DATA_PORT0, 8'hA5}, 1'b1, '{8'h00, 1'b1}},
		// RAM writes at lowest and highest offset
		'{'{1'b1, CMD_PORT0, ecmb_pkg::CMD_WRITE_MEM}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, DATA_PORT0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, DATA_PORT0, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, CMD_PORT0, ecmb_pkg::CMD_WRITE_MEM}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, DATA_PORT0, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, DATA_PORT0, 8'h5A}, 1'b1, '{8'h00, 1'b1}},
		// read back offset 0, status shows buffer full then empty
		'{'{1'b1, CMD_PORT0, ecmb_pkg::CMD_READ_MEM}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, DATA_PORT0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b0, CMD_PORT0, 8'h00}, 1'b1, '{OBF_SET, 1'b1}},
		'{'{1'b0, DATA_PORT0, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		'{'{1'b0, CMD_PORT0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
		// data read with the buffer empty keeps the last byte
		'{'{1'b0, DATA_PORT0, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		// second read overwrites an unread byte
		'{'{1'b1, CMD_PORT0, ecmb_pkg::CMD_READ_MEM}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, DATA_PORT0, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, CMD_PORT0, ecmb_pkg::CMD_READ_MEM}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, DATA_PORT0, 8'h07}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b0, DATA_PORT0, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		// unknown command abandons a write, the following data is stray
		'{'{1'b1, CMD_PORT0, ecmb_pkg::CMD_WRITE_MEM}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, CMD_PORT0, CMD_UNKNOWN}, 1'b1, '{8'h00, 1'b1}},
		'{'{1'b1, DATA_PORT0, 8'h33}, 1'b1, '{8'h00, 1'b1}}
	};

	ec_host_mailbox_ram u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Reply to one access, advancing the mirrored mailbox state
	function automatic host_reply_t predict_access(host_access_t a);
		host_reply_t r;
		logic [15:0] dport;
		r = '0;
		dport = ec_cmd_port - ecmb_pkg::DATA_PORT_OFFSET;
		if (a.addr == ec_cmd_port) begin
			r.claimed = 1'b1;
			if (a.is_wr) begin
				case (a.byte_in)
					ecmb_pkg::CMD_READ_MEM: ec_phase = PH_RD_OFF;
					ecmb_pkg::CMD_WRITE_MEM: ec_phase = PH_WR_OFF;
					default: ec_phase = PH_IDLE;
				endcase
			end else begin
				// input buffer never reads full
				r.rd_byte = ec_obf ? OBF_SET : 8'h00;
			end
		end else if (a.addr == dport) begin
			r.claimed = 1'b1;
			if (a.is_wr) begin
				case (ec_phase)
					PH_RD_OFF: begin
						ec_offset = a.byte_in;
						ec_obuf = (int'(a.byte_in) < ecmb_pkg::MEMORY_DEPTH) ?
							ec_ram[a.byte_in] : 8'h00;
						ec_obf = 1'b1;
						ec_phase = PH_IDLE;
					end
					PH_WR_OFF: begin
						ec_offset = a.byte_in;
						ec_phase = PH_WR_VAL;
					end
					PH_WR_VAL: begin
						if (int'(ec_offset) < ecmb_pkg::MEMORY_DEPTH)
							ec_ram[ec_offset] = a.byte_in;
						ec_phase = PH_IDLE;
					end
					default: ;
				endcase
			end else begin
				r.rd_byte = ec_obuf;
				ec_obf = 1'b0;
			end
		end
		return r;
	endfunction

	// Check returned words against the oldest expectation, then log new accesses
	always @(posedge clk) begin
		if (!arst_n) begin
			foreach (ec_ram[i])
				ec_ram[i] = 8'h00;
			ec_phase = PH_IDLE;
			ec_offset = 8'h00;
			ec_obuf = 8'h00;
			ec_obf = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (reply_q.size() == 0) begin
					$display("%0t: unexpected word read_data %h claimed %b", $time,
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want_reply = reply_q.pop_front();
					if (m_axis_tdata !== want_reply.rd_byte) begin
						$display("%0t: read_data expected %h got %h", $time,
							want_reply.rd_byte, m_axis_tdata);
						errors++;
					end
					if (m_axis_tuser !== want_reply.claimed) begin
						$display("%0t: claimed expected %b got %b", $time,
							want_reply.claimed, m_axis_tuser);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen_acc.is_wr = s_axis_tuser;
				seen_acc.addr = s_axis_tdata[15:0];
				seen_acc.byte_in = s_axis_tdata[23:16];
				next_reply = predict_access(seen_acc);
				if (row_exact)
					next_reply = row_reply;
				reply_q.push_back(next_reply);
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: counts cycles with work pending but no word moving
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (!s_axis_tvalid && reply_q.size() == 0)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, stall_cycles);
			$display("ec_host_mailbox_ram: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic host_access_t mk_access(logic is_wr, logic [15:0] addr, logic [7:0] b);
		host_access_t a;
		a.is_wr = is_wr;
		a.addr = addr;
		a.byte_in = b;
		return a;
	endfunction

	// Mostly low offsets so reads find written bytes
	function automatic logic [7:0] pick_offset();
		return $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
	endfunction

	// Junk access: anywhere, or just beside the two ports
	function automatic host_access_t noise_access(logic [15:0] cp, logic [15:0] dp);
		logic [15:0] addr;
		case ($urandom_range(3))
			0: addr = cp + 16'd1;
			1: addr = dp - 16'd1;
			default: addr = 16'($urandom_range(65535));
		endcase
		return mk_access(1'($urandom_range(1)), addr, 8'($urandom_range(255)));
	endfunction

	task automatic wait_drained();
		@(posedge clk);
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Present one word, with random sender gaps, and hold until taken
	task automatic send_access(host_access_t a, logic exact, host_reply_t reply);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {a.byte_in, a.addr};
		s_axis_tuser <= a.is_wr;
		row_exact <= exact;
		row_reply <= reply;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_count++;
		if (pressure_on && (sent_count % 64 == 0)) begin
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end
	endtask

	task automatic send_rand(host_access_t a);
		send_access(a, 1'b0, '0);
	endtask

	// Port address only changes with the mailbox drained
	task automatic write_command_port(logic [15:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		ec_cmd_port = value;
		@(posedge clk);
	endtask

	// Random traffic: mostly complete transactions, some aborts and junk
	task automatic run_phase(int n, int sidle, int rstall, bit pressure);
		int stop;
		int r;
		logic [15:0] cp;
		logic [15:0] dp;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		pressure_on = pressure;
		stop = sent_count + n;
		cp = ec_cmd_port;
		dp = cp - ecmb_pkg::DATA_PORT_OFFSET;
		while (sent_count < stop) begin
			r = $urandom_range(99);
			if (r < 35) begin
				send_rand(mk_access(1'b1, cp, ecmb_pkg::CMD_WRITE_MEM));
				if ($urandom_range(9) == 0)
					send_rand(noise_access(cp, dp));
				send_rand(mk_access(1'b1, dp, pick_offset()));
				send_rand(mk_access(1'b1, dp, 8'($urandom_range(255))));
			end else if (r < 65) begin
				send_rand(mk_access(1'b1, cp, ecmb_pkg::CMD_READ_MEM));
				send_rand(mk_access(1'b1, dp, pick_offset()));
				if ($urandom_range(1))
					send_rand(mk_access(1'b0, cp, 8'($urandom_range(255))));
				send_rand(mk_access(1'b0, dp, 8'($urandom_range(255))));
				if ($urandom_range(2) == 0)
					send_rand(mk_access(1'b0, cp, 8'($urandom_range(255))));
			end else if (r < 75) begin
				send_rand(mk_access(1'b0, $urandom_range(1) ? cp : dp, 8'($urandom_range(255))));
			end else if (r < 85) begin
				// abandoned transaction: another command, or a stray data write after it
				send_rand(mk_access(1'b1, cp,
					$urandom_range(1) ? ecmb_pkg::CMD_READ_MEM : ecmb_pkg::CMD_WRITE_MEM));
				send_rand(mk_access(1'b1, cp, 8'($urandom_range(255))));
				if ($urandom_range(1))
					send_rand(mk_access(1'b1, dp, 8'($urandom_range(255))));
			end else begin
				send_rand(noise_access(cp, dp));
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		row_exact = 1'b0;
		row_reply = '0;
		ec_cmd_port = ecmb_pkg::COMMAND_PORT_RESET;
		sent_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pressure_on = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset port address
		foreach (dir_tab[i])
			send_access(dir_tab[i].acc, dir_tab[i].exact, dir_tab[i].reply);
		s_axis_tvalid <= 1'b0;

		// Random phases: data port at zero, command port at top, wrapped, random, default
		write_command_port(16'h0004);
		run_phase(320, 0, 0, 1'b0);
		write_command_port(16'hFFFF);
		run_phase(300, 50, 0, 1'b0);
		write_command_port(16'h0002);
		run_phase(300, 0, 50, 1'b0);
		write_command_port(16'($urandom_range(65535, 4)));
		run_phase(300, 20, 20, 1'b0);
		write_command_port(ecmb_pkg::COMMAND_PORT_RESET);
		run_phase(300, 20, 20, 1'b1);

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("ec_host_mailbox_ram: match");
		else
			$display("ec_host_mailbox_ram: mismatch");
		$finish;
	end

endmodule
